// ===== rtl/qmsc_pkg.sv =====
// Package for the quad multisample coverage block: payload words, edge record,
// register indexes, sizing constants and width helpers. No dependencies.
`timescale 1ns / 1ps

package qmsc_pkg;

  localparam int CoordBitsDefault = 10;
  localparam int NumEdges   = 3;
  localparam int NumPixels  = 4;
  localparam int NumSamples = 3;
  localparam int CoefW      = 24;
  localparam int ConstW     = 48;
  localparam int OffW       = 4;
  localparam int OffRegW    = 24;
  localparam int CfgAddrW   = 5;
  localparam int CfgDataW   = 32;
  // Offset plus one pixel step in twelfths fits in five bits (at most 27).
  localparam int PosW       = 5;
  // Width of a*pos + b*pos for the in-pixel sample position.
  localparam int OffSumW    = CoefW + PosW + 3;

  localparam logic [OffW-1:0] CentreOff = 4'd6;
  localparam logic [1:0]      RepCentre = 2'd3;

  typedef enum logic [2:0] {
    RegMsEnable = 3'd0,
    RegPix0Off  = 3'd1,
    RegPix1Off  = 3'd2,
    RegPix2Off  = 3'd3,
    RegPix3Off  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        [9:0]        quad_x;
    logic        [9:0]        quad_y;
    logic signed [CoefW-1:0]  edge0_a;
    logic signed [CoefW-1:0]  edge0_b;
    logic signed [ConstW-1:0] edge0_c;
    logic signed [CoefW-1:0]  edge1_a;
    logic signed [CoefW-1:0]  edge1_b;
    logic signed [ConstW-1:0] edge1_c;
    logic signed [CoefW-1:0]  edge2_a;
    logic signed [CoefW-1:0]  edge2_b;
    logic signed [ConstW-1:0] edge2_c;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  out_quad_x;
    logic [9:0]  out_quad_y;
    logic [11:0] coverage_mask;
    logic [3:0]  pixel_covered;
    logic [1:0]  rep_sample_p0;
    logic [1:0]  rep_sample_p1;
    logic [1:0]  rep_sample_p2;
    logic [1:0]  rep_sample_p3;
  } out_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic signed [ConstW-1:0] c;
  } edge_t;

  // Width of a coefficient times a quad origin in twelfths.
  function automatic int prod_width(int coord_bits);
    return CoefW + coord_bits + 5;
  endfunction

  // Width of the full edge value, with headroom for the sums.
  function automatic int edge_width(int coord_bits);
    int pw;
    pw = prod_width(coord_bits);
    return ((pw > ConstW) ? pw : ConstW) + 3;
  endfunction

  function automatic edge_t get_edge(in_word_t w, logic [1:0] k);
    edge_t e;
    case (k)
      2'd0: e = '{a: w.edge0_a, b: w.edge0_b, c: w.edge0_c};
      2'd1: e = '{a: w.edge1_a, b: w.edge1_b, c: w.edge1_c};
      default: e = '{a: w.edge2_a, b: w.edge2_b, c: w.edge2_c};
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/qmsc_edge_setup.sv =====
// Per-edge setup: evaluates each edge equation at the quad origin in twelfths
// of a pixel over two stages, plus the top-left tie flag. Uses qmsc_pkg.
`timescale 1ns / 1ps

module qmsc_edge_setup #(
  parameter int COORD_BITS = qmsc_pkg::CoordBitsDefault
) (
  input  logic                    clk_i,
  input  logic [COORD_BITS-1:0]   qx_i,
  input  logic [COORD_BITS-1:0]   qy_i,
  input  qmsc_pkg::edge_t         edges_i [qmsc_pkg::NumEdges],
  output logic signed [qmsc_pkg::edge_width(COORD_BITS)-1:0] base_o [qmsc_pkg::NumEdges],
  output logic [qmsc_pkg::NumEdges-1:0] tl_o
);
  import qmsc_pkg::*;

  localparam int PW = prod_width(COORD_BITS);
  localparam int EW = edge_width(COORD_BITS);
  localparam int QW = COORD_BITS + 4;

  logic [QW-1:0] qx12, qy12;
  logic signed [PW-1:0]     pa_q [NumEdges];
  logic signed [PW-1:0]     pb_q [NumEdges];
  logic signed [ConstW-1:0] c_q  [NumEdges];
  logic signed [CoefW-1:0]  a_q  [NumEdges];
  logic signed [CoefW-1:0]  b_q  [NumEdges];
  logic signed [EW-1:0]     base_q [NumEdges];
  logic [NumEdges-1:0]      tl_q;

  // Twelve times the origin as 8x + 4x.
  assign qx12 = QW'({qx_i, 3'b000}) + QW'({qx_i, 2'b00});
  assign qy12 = QW'({qy_i, 3'b000}) + QW'({qy_i, 2'b00});

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumEdges; k++) begin
      pa_q[k] <= PW'(edges_i[k].a) * PW'($signed({1'b0, qx12}));
      pb_q[k] <= PW'(edges_i[k].b) * PW'($signed({1'b0, qy12}));
      c_q[k]  <= edges_i[k].c;
      a_q[k]  <= edges_i[k].a;
      b_q[k]  <= edges_i[k].b;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumEdges; k++) begin
      base_q[k] <= EW'(pa_q[k]) + EW'(pb_q[k]) + EW'(c_q[k]);
      // A zero edge value counts as inside on a top or left edge.
      tl_q[k]   <= (b_q[k] > 0) || ((b_q[k] == 0) && (a_q[k] > 0));
    end
  end

  assign base_o = base_q;
  assign tl_o   = tl_q;

endmodule

// ===== rtl/qmsc_pixel_lane.sv =====
// One pixel lane: tests each of the pixel's sub-samples against every edge
// using the shared per-edge origin values. Uses qmsc_pkg.
`timescale 1ns / 1ps

module qmsc_pixel_lane #(
  parameter int COORD_BITS = qmsc_pkg::CoordBitsDefault,
  parameter int PIX        = 0
) (
  input  logic                            clk_i,
  input  logic                            ms_enable_i,
  input  logic [qmsc_pkg::OffRegW-1:0]    offsets_i,
  input  qmsc_pkg::edge_t                 edges_i [qmsc_pkg::NumEdges],
  input  logic signed [qmsc_pkg::edge_width(COORD_BITS)-1:0] base_i [qmsc_pkg::NumEdges],
  input  logic [qmsc_pkg::NumEdges-1:0]   tl_i,
  output logic [qmsc_pkg::NumSamples-1:0] cov_o
);
  import qmsc_pkg::*;

  localparam int EW = edge_width(COORD_BITS);
  localparam logic [PosW-1:0] StepX = ((PIX % 2) != 0) ? PosW'(12) : PosW'(0);
  localparam logic [PosW-1:0] StepY = ((PIX / 2) != 0) ? PosW'(12) : PosW'(0);

  logic [PosW-1:0] xo [NumSamples];
  logic [PosW-1:0] yo [NumSamples];
  logic signed [OffSumW-1:0] ao_q [NumSamples][NumEdges];
  logic signed [OffSumW-1:0] bo_q [NumSamples][NumEdges];
  logic signed [OffSumW-1:0] os_q [NumSamples][NumEdges];
  logic [NumSamples-1:0] cov_q;

  always_comb begin
    for (int s = 0; s < NumSamples; s++) begin
      if (ms_enable_i) begin
        xo[s] = StepX + PosW'(offsets_i[8*s +: OffW]);
        yo[s] = StepY + PosW'(offsets_i[8*s+4 +: OffW]);
      end else begin
        xo[s] = StepX + PosW'(CentreOff);
        yo[s] = StepY + PosW'(CentreOff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumSamples; s++) begin
      for (int k = 0; k < NumEdges; k++) begin
        ao_q[s][k] <= OffSumW'(edges_i[k].a) * OffSumW'($signed({1'b0, xo[s]}));
        bo_q[s][k] <= OffSumW'(edges_i[k].b) * OffSumW'($signed({1'b0, yo[s]}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumSamples; s++) begin
      for (int k = 0; k < NumEdges; k++) begin
        os_q[s][k] <= ao_q[s][k] + bo_q[s][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumSamples; s++) begin
      logic ok;
      logic signed [EW-1:0] e;
      ok = 1'b1;
      for (int k = 0; k < NumEdges; k++) begin
        e = base_i[k] + EW'(os_q[s][k]);
        if (e < 0 || (e == 0 && !tl_i[k])) begin
          ok = 1'b0;
        end
      end
      cov_q[s] <= ok;
    end
  end

  assign cov_o = cov_q;

endmodule

// ===== rtl/qmsc_merge.sv =====
// Merge stage: folds the four lane coverage results into the mask, the
// per-pixel flags and the representative samples. Uses qmsc_pkg.
`timescale 1ns / 1ps

module qmsc_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [9:0]          quad_x_i,
  input  logic [9:0]          quad_y_i,
  input  logic [11:0]         mask_i,
  output logic                done_o,
  output qmsc_pkg::out_word_t out_word_o
);
  import qmsc_pkg::*;

  logic      done_q;
  out_word_t out_q, out_d;
  logic [1:0] rep [NumPixels];
  logic [NumPixels-1:0] pcov;

  always_comb begin
    for (int p = 0; p < NumPixels; p++) begin
      logic [NumSamples-1:0] c;
      c = mask_i[3*p +: NumSamples];
      pcov[p] = |c;
      if (&c) begin
        rep[p] = RepCentre;
      end else if (c[0]) begin
        rep[p] = 2'd0;
      end else if (c[1]) begin
        rep[p] = 2'd1;
      end else if (c[2]) begin
        rep[p] = 2'd2;
      end else begin
        rep[p] = RepCentre;
      end
    end
    out_d = '{out_quad_x: quad_x_i, out_quad_y: quad_y_i, coverage_mask: mask_i,
              pixel_covered: pcov, rep_sample_p0: rep[0], rep_sample_p1: rep[1],
              rep_sample_p2: rep[2], rep_sample_p3: rep[3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

endmodule

// ===== rtl/quad_multisample_coverage_top.sv =====
// Top level of the quad multisample coverage block: command port, register
// file and pipeline. Depends on qmsc_pkg, qmsc_edge_setup, qmsc_pixel_lane,
// qmsc_merge.
`timescale 1ns / 1ps

//  Channel   | Signals                                   | Transfer
//  ----------+-------------------------------------------+------------------------------
//  command   | start, busy, in_word_i                    | start high while busy low
//  result    | done_o, out_word_o                        | one cycle with done_o high
//  registers | psel, penable, pwrite, paddr, pwdata, ... | access phase, pready always high
//
// One word is accepted every clock; busy is tied low since every stage moves
// each cycle. A result appears with done_o once the word has passed these registers:
// input register, origin products, origin sum with lane offset sums, lane
// compare, merge register. The depth is set by the edge setup multiplier and
// the wide edge sum. The receiver cannot stall, so no backpressure exists.
// Reset clears the pipeline valid bits and the configuration registers
// (multisampling off, all offsets at pixel centre).
// Configuration must be written only while no word is in flight.
module quad_multisample_coverage_top #(
  parameter int COORD_BITS = qmsc_pkg::CoordBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  qmsc_pkg::in_word_t              in_word_i,
  output logic                            done_o,
  output qmsc_pkg::out_word_t             out_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qmsc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [qmsc_pkg::CfgDataW-1:0]   pwdata,
  output logic [qmsc_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import qmsc_pkg::*;

  localparam int EW = edge_width(COORD_BITS);

  // Configuration registers.
  logic               ms_enable_q;
  logic [OffRegW-1:0] offsets_q [NumPixels];
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  // Pipeline control and payload.
  logic       v0_q, v1_q, v2_q, v3_q;
  in_word_t   in_q;
  logic [9:0] qx_q [3];
  logic [9:0] qy_q [3];
  edge_t      edges [NumEdges];
  logic signed [EW-1:0] base [NumEdges];
  logic [NumEdges-1:0]  tl;
  logic [11:0] mask;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register file. Writes beyond the last register are dropped.
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_enable_q <= 1'b0;
      for (int p = 0; p < NumPixels; p++) begin
        offsets_q[p] <= {NumSamples*2{CentreOff}};
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        RegMsEnable: ms_enable_q  <= pwdata[0];
        RegPix0Off:  offsets_q[0] <= pwdata[OffRegW-1:0];
        RegPix1Off:  offsets_q[1] <= pwdata[OffRegW-1:0];
        RegPix2Off:  offsets_q[2] <= pwdata[OffRegW-1:0];
        RegPix3Off:  offsets_q[3] <= pwdata[OffRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMsEnable: prdata = CfgDataW'(ms_enable_q);
      RegPix0Off:  prdata = CfgDataW'(offsets_q[0]);
      RegPix1Off:  prdata = CfgDataW'(offsets_q[1]);
      RegPix2Off:  prdata = CfgDataW'(offsets_q[2]);
      RegPix3Off:  prdata = CfgDataW'(offsets_q[3]);
      default:     prdata = '0;
    endcase
  end

  // Valid bits follow the word down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // The input word is captured on acceptance; the quad position then rides a
  // short delay line alongside the lanes so the merge stage can pass it out.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= in_word_i;
    end
    qx_q[0] <= in_q.quad_x;
    qy_q[0] <= in_q.quad_y;
    for (int i = 1; i < 3; i++) begin
      qx_q[i] <= qx_q[i-1];
      qy_q[i] <= qy_q[i-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      edges[k] = get_edge(in_q, 2'(k));
    end
  end

  // Origin values of every edge, shared by all lanes.
  qmsc_edge_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk_i   (clk_i),
    .qx_i    (COORD_BITS'(in_q.quad_x)),
    .qy_i    (COORD_BITS'(in_q.quad_y)),
    .edges_i (edges),
    .base_o  (base),
    .tl_o    (tl)
  );

  // One lane per pixel of the quad; each adds its own sample offsets.
  for (genvar p = 0; p < NumPixels; p++) begin : g_lane
    qmsc_pixel_lane #(
      .COORD_BITS (COORD_BITS),
      .PIX        (p)
    ) u_lane (
      .clk_i       (clk_i),
      .ms_enable_i (ms_enable_q),
      .offsets_i   (offsets_q[p]),
      .edges_i     (edges),
      .base_i      (base),
      .tl_i        (tl),
      .cov_o       (mask[3*p +: NumSamples])
    );
  end

  qmsc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3_q),
    .quad_x_i   (qx_q[2]),
    .quad_y_i   (qy_q[2]),
    .mask_i     (mask),
    .done_o     (done_o),
    .out_word_o (out_word_o)
  );

endmodule

// ===== tb/tb_quad_multisample_coverage_top.sv =====
// Self-checking testbench for quad_multisample_coverage_top: drives quads and edge
// equations, programs sample offsets over APB and checks every coverage word.
// Depends on qmsc_pkg and quad_multisample_coverage_top.
`timescale 1ns / 1ps

module tb_quad_multisample_coverage_top;
  import qmsc_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int CoordBits = CoordBitsDefault;
  // Drain wait, longer than the block's pipeline, so no word is left in flight.
  localparam int DrainCycles = 8;

  localparam longint CoefMax  = 64'sd8388607;
  localparam longint CoefMin  = -64'sd8388608;
  localparam longint ConstMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint ConstMin = -64'sh8000_0000_0000;
  localparam logic [23:0] CentreOffsets = 24'h666666;

  // Every input of the block holds a known value from time zero.
  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_word_t            in_word_i = '0;
  logic                done_o;
  out_word_t           out_word_o;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [CfgDataW-1:0] pwdata    = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Shadow of the configuration registers, starting from their reset values.
  logic        ms_on = 1'b0;
  logic [23:0] pix_offs [4] = '{4{CentreOffsets}};

  // Quads waiting to be sent, and coverage words the block still owes us.
  in_word_t  quads_to_send [$];
  out_word_t coverage_due [$];

  // When set, the sender never leaves a gap between words.
  bit no_gaps = 1'b0;

  int errors      = 0;
  int n_checked   = 0;
  int n_settings  = 0;
  int n_reads     = 0;
  int n_full      = 0;
  int n_partial   = 0;
  int n_empty     = 0;

  quad_multisample_coverage_top #(
    .COORD_BITS(CoordBits)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_word_i (in_word_i),
    .done_o    (done_o),
    .out_word_o(out_word_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Counts a failure; only the first ten are described in the log.
  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Coverage of one quad under the current register settings. Positions are in
  // twelfths of a pixel, the constant term is already scaled by twelve, and a
  // sample is inside when every edge value is positive, or zero on a top edge
  // (b > 0) or a left edge (b == 0, a > 0).
  function automatic out_word_t quad_coverage(in_word_t w);
    longint     ea [3];
    longint     eb [3];
    longint     ec [3];
    longint     qx, qy, bx, by, sx, sy, val;
    logic [3:0] ox, oy;
    logic [2:0] hit;
    logic [1:0] rep [4];
    logic       in_tri;
    int         first;
    out_word_t  r;

    ea[0] = w.edge0_a;  eb[0] = w.edge0_b;  ec[0] = w.edge0_c;
    ea[1] = w.edge1_a;  eb[1] = w.edge1_b;  ec[1] = w.edge1_c;
    ea[2] = w.edge2_a;  eb[2] = w.edge2_b;  ec[2] = w.edge2_c;
    qx = longint'(w.quad_x) & ((64'sd1 <<< CoordBits) - 1);
    qy = longint'(w.quad_y) & ((64'sd1 <<< CoordBits) - 1);

    r = '0;
    r.out_quad_x = w.quad_x;
    r.out_quad_y = w.quad_y;
    for (int p = 0; p < NumPixels; p++) begin
      bx    = 12 * (qx + (p & 1));
      by    = 12 * (qy + (p >> 1));
      hit   = '0;
      first = 3;
      for (int s = 0; s < NumSamples; s++) begin
        ox = ms_on ? pix_offs[p][8*s +: 4]     : CentreOff;
        oy = ms_on ? pix_offs[p][8*s + 4 +: 4] : CentreOff;
        sx = bx + longint'(ox);
        sy = by + longint'(oy);
        in_tri = 1'b1;
        for (int k = 0; k < NumEdges; k++) begin
          val = ea[k] * sx + eb[k] * sy + ec[k];
          if (val < 0 || (val == 0 && !(eb[k] > 0 || (eb[k] == 0 && ea[k] > 0)))) begin
            in_tri = 1'b0;
          end
        end
        if (in_tri) begin
          if (hit == '0) begin
            first = s;
          end
          hit[s] = 1'b1;
        end
      end
      r.coverage_mask[3*p +: 3] = hit;
      r.pixel_covered[p]        = |hit;
      // A fully covered pixel is evaluated at its centre; an uncovered one too.
      rep[p] = (&hit) ? RepCentre : 2'(first);
    end
    r.rep_sample_p0 = rep[0];
    r.rep_sample_p1 = rep[1];
    r.rep_sample_p2 = rep[2];
    r.rep_sample_p3 = rep[3];
    return r;
  endfunction

  // A quad whose coverage is decided by edge 0 alone; the other edges
  // hold everywhere.
  function automatic in_word_t one_edge(logic [9:0] qx, logic [9:0] qy,
                                        longint a, longint b, longint c);
    in_word_t w;
    w         = '0;
    w.quad_x  = qx;
    w.quad_y  = qy;
    w.edge0_a = a[23:0];
    w.edge0_b = b[23:0];
    w.edge0_c = c[47:0];
    w.edge1_c = 48'sd1;
    w.edge2_c = 48'sd1;
    return w;
  endfunction

  // Mostly triangles whose edges pass through the quad, often exactly through
  // one of its programmed samples so that the top-left rule decides; the rest
  // is raw noise over every bit of the word.
  function automatic in_word_t random_quad();
    in_word_t     w;
    logic [319:0] raw;
    longint       a [3];
    longint       b [3];
    longint       c [3];
    longint       px, py;
    logic [3:0]   ox, oy;
    int           sh, p, s;

    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 10; i++) begin
        raw[32*i +: 32] = $urandom;
      end
      w = raw[$bits(in_word_t)-1:0];
      return w;
    end

    w        = '0;
    w.quad_x = 10'($urandom_range(0, 1023));
    w.quad_y = 10'($urandom_range(0, 1023));
    // Quads normally sit on even positions; an odd one now and then.
    if ($urandom_range(0, 7) != 0) begin
      w.quad_x[0] = 1'b0;
      w.quad_y[0] = 1'b0;
    end

    for (int k = 0; k < NumEdges; k++) begin
      sh   = $urandom_range(0, 23);
      a[k] = longint'($urandom_range(0, (32'd2 << sh) - 1)) - (64'sd1 <<< sh);
      sh   = $urandom_range(0, 23);
      b[k] = longint'($urandom_range(0, (32'd2 << sh) - 1)) - (64'sd1 <<< sh);
      if ($urandom_range(0, 7) == 0) begin
        a[k] = 0;
      end
      if ($urandom_range(0, 7) == 0) begin
        b[k] = 0;
      end
      // Anchor the line on one real sample position of the quad.
      p  = $urandom_range(0, 3);
      s  = $urandom_range(0, 2);
      ox = ms_on ? pix_offs[p][8*s +: 4]     : CentreOff;
      oy = ms_on ? pix_offs[p][8*s + 4 +: 4] : CentreOff;
      px = 12 * (longint'(w.quad_x) + (p & 1)) + longint'(ox);
      py = 12 * (longint'(w.quad_y) + (p >> 1)) + longint'(oy);
      c[k] = -(a[k] * px + b[k] * py);
      // Shift the line by a few twelfths most of the time.
      if ($urandom_range(0, 2) != 0) begin
        c[k] += (longint'($urandom_range(0, 30)) - 15) * a[k]
              + (longint'($urandom_range(0, 30)) - 15) * b[k];
      end
      if ($urandom_range(0, 5) == 0) begin
        c[k] += longint'($urandom_range(0, 6)) - 3;
      end
      // Some edges are left out of play so the intersection is not always empty.
      if ($urandom_range(0, 3) == 0) begin
        a[k] = 0;
        b[k] = 0;
        c[k] = longint'($urandom_range(1, 32'hFFFF_FFFF));
      end
    end

    w.edge0_a = a[0][23:0];  w.edge0_b = b[0][23:0];  w.edge0_c = c[0][47:0];
    w.edge1_a = a[1][23:0];  w.edge1_b = b[1][23:0];  w.edge1_c = c[1][47:0];
    w.edge2_a = a[2][23:0];  w.edge2_b = b[2][23:0];  w.edge2_c = c[2][47:0];
    return w;
  endfunction

  // Sender. A word is taken at an edge where start is high and busy low; the
  // coverage it must produce is worked out at that same edge. The next word is
  // then loaded, or start drops for a random gap or while no quad is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (start && !busy) begin
        coverage_due.push_back(quad_coverage(in_word_i));
      end
      if (!start || !busy) begin
        if (quads_to_send.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 20)) begin
          start     <= 1'b1;
          in_word_i <= quads_to_send.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each strobed word is compared, field by field, with the oldest
  // coverage still owed; the block cannot be stalled, so it is taken as it comes.
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    logic [1:0] rep [4];
    if (rst_ni && done_o) begin
      if (coverage_due.size() == 0) begin
        note_failure($sformatf("unexpected word for quad (%0d,%0d)",
                               out_word_o.out_quad_x, out_word_o.out_quad_y));
      end else begin
        want = coverage_due.pop_front();
        n_checked++;
        if (out_word_o.out_quad_x    !== want.out_quad_x    ||
            out_word_o.out_quad_y    !== want.out_quad_y    ||
            out_word_o.coverage_mask !== want.coverage_mask ||
            out_word_o.pixel_covered !== want.pixel_covered ||
            out_word_o.rep_sample_p0 !== want.rep_sample_p0 ||
            out_word_o.rep_sample_p1 !== want.rep_sample_p1 ||
            out_word_o.rep_sample_p2 !== want.rep_sample_p2 ||
            out_word_o.rep_sample_p3 !== want.rep_sample_p3) begin
          note_failure($sformatf(
            "quad exp (%0d,%0d) mask %h cov %h rep %0d%0d%0d%0d, got (%0d,%0d) mask %h cov %h rep %0d%0d%0d%0d",
            want.out_quad_x, want.out_quad_y, want.coverage_mask, want.pixel_covered,
            want.rep_sample_p0, want.rep_sample_p1, want.rep_sample_p2, want.rep_sample_p3,
            out_word_o.out_quad_x, out_word_o.out_quad_y, out_word_o.coverage_mask,
            out_word_o.pixel_covered, out_word_o.rep_sample_p0, out_word_o.rep_sample_p1,
            out_word_o.rep_sample_p2, out_word_o.rep_sample_p3));
        end
        rep = '{want.rep_sample_p0, want.rep_sample_p1, want.rep_sample_p2, want.rep_sample_p3};
        for (int p = 0; p < NumPixels; p++) begin
          if (!want.pixel_covered[p]) begin
            n_empty++;
          end else if (rep[p] == RepCentre) begin
            n_full++;
          end else begin
            n_partial++;
          end
        end
      end
    end
  end

  // APB write: setup cycle, then the access cycle whose closing edge writes.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMsEnable) begin
      ms_on = val[0];
    end else begin
      pix_offs[int'(idx) - int'(RegPix0Off)] = val[23:0];
    end
  endtask

  // APB read, checked against the shadow copy at the edge ending the access.
  task automatic cfg_check(input reg_idx_e idx);
    logic [31:0] want;
    want = (idx == RegMsEnable) ? {31'b0, ms_on}
                                : {8'b0, pix_offs[int'(idx) - int'(RegPix0Off)]};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CfgAddrW'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_reads++;
    if (prdata !== want) begin
      note_failure($sformatf("register %s read %h, expected %h", idx.name(), prdata, want));
    end
  endtask

  // Holds until every queued quad is sent and every owed word has come back,
  // then lets the pipeline run empty before anything else happens.
  task automatic wait_drained();
    while (quads_to_send.size() > 0 || start || coverage_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register setting: write every register (upper data bits carry noise
  // that the block must drop), read them back, then send random quads in two
  // halves with a full drain between them.
  task automatic run_phase(input logic ms, input logic [23:0] offs [4], input int n_quads,
                           input bit steady);
    for (int p = 0; p < NumPixels; p++) begin
      cfg_write(reg_idx_e'(int'(RegPix0Off) + p), {8'($urandom), offs[p]});
    end
    cfg_write(RegMsEnable, {31'($urandom), ms});
    for (int i = int'(RegMsEnable); i <= int'(RegPix3Off); i++) begin
      cfg_check(reg_idx_e'(i));
    end
    no_gaps = steady;
    @(negedge clk_i);
    for (int n = 0; n < n_quads / 2; n++) begin
      quads_to_send.push_back(random_quad());
    end
    wait_drained();
    @(negedge clk_i);
    for (int n = n_quads / 2; n < n_quads; n++) begin
      quads_to_send.push_back(random_quad());
    end
    wait_drained();
    no_gaps = 1'b0;
    n_settings++;
  endtask

  initial begin : main_seq
    logic [23:0] offs [4];
    in_word_t    w;
    int          spin;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, before any write.
    for (int i = int'(RegMsEnable); i <= int'(RegPix3Off); i++) begin
      cfg_check(reg_idx_e'(i));
    end

    // Directed quads with multisampling off. Around quad (100,200) the pixel 0
    // centre is X = 1206, Y = 2406 in twelfths.
    @(negedge clk_i);
    quads_to_send.push_back(one_edge(0, 0, 0, 0, 1));            // all inside
    quads_to_send.push_back(one_edge(0, 0, 0, 0, -1));           // all outside
    quads_to_send.push_back(one_edge(0, 0, 0, 0, 0));            // zero, neither top nor left
    quads_to_send.push_back(one_edge(100, 200, 1, 0, -1206));    // left edge on centres
    quads_to_send.push_back(one_edge(100, 200, -1, 0, 1206));    // right edge on centres
    quads_to_send.push_back(one_edge(100, 200, 0, 1, -2406));    // top edge on centres
    quads_to_send.push_back(one_edge(100, 200, 0, -1, 2406));    // bottom edge on centres
    quads_to_send.push_back(one_edge(100, 200, 1, 0, -1212));    // right column only
    quads_to_send.push_back(one_edge(100, 200, 0, 1, -2412));    // bottom row only
    quads_to_send.push_back(one_edge(100, 200, 1, 1, -3624));    // diagonal through two centres
    quads_to_send.push_back(one_edge(1023, 1023, CoefMax, CoefMin, ConstMax));
    quads_to_send.push_back(one_edge(1022, 0, CoefMin, CoefMax, ConstMin));
    quads_to_send.push_back(one_edge(0, 1023, CoefMax, CoefMax, ConstMin));
    quads_to_send.push_back(one_edge(1023, 0, CoefMin, CoefMin, ConstMax));
    quads_to_send.push_back(one_edge(101, 201, 1, 0, -1218));    // odd origin
    // Two real edges cut out the bottom-right pixel alone.
    w = one_edge(100, 200, 1, 0, -1212);
    w.edge1_b = 24'sd1;
    w.edge1_c = -48'sd2412;
    quads_to_send.push_back(w);
    // All the edges meet at the pixel 0 centre, each on its top-left side.
    w = one_edge(100, 200, 1, 0, -1206);
    w.edge1_b = 24'sd1;
    w.edge1_c = -48'sd2406;
    w.edge2_a = 24'sd2;
    w.edge2_c = -48'sd2412;
    quads_to_send.push_back(w);
    // Every field at its largest, then every field at its smallest.
    w = '{quad_x: 10'h3FF, quad_y: 10'h3FF,
          edge0_a: CoefMax[23:0], edge0_b: CoefMax[23:0], edge0_c: ConstMax[47:0],
          edge1_a: CoefMax[23:0], edge1_b: CoefMax[23:0], edge1_c: ConstMax[47:0],
          edge2_a: CoefMax[23:0], edge2_b: CoefMax[23:0], edge2_c: ConstMax[47:0]};
    quads_to_send.push_back(w);
    w = '{quad_x: 10'h0, quad_y: 10'h0,
          edge0_a: CoefMin[23:0], edge0_b: CoefMin[23:0], edge0_c: ConstMin[47:0],
          edge1_a: CoefMin[23:0], edge1_b: CoefMin[23:0], edge1_c: ConstMin[47:0],
          edge2_a: CoefMin[23:0], edge2_b: CoefMin[23:0], edge2_c: ConstMin[47:0]};
    quads_to_send.push_back(w);
    for (int n = 0; n < 100; n++) begin
      quads_to_send.push_back(random_quad());
    end
    wait_drained();
    n_settings++;

    // Multisampling on but every offset at the centre: a stretch with no gaps.
    run_phase(1'b1, '{4{CentreOffsets}}, 100, 1'b1);
    // Offset extremes: every sample at the far top-left, then far bottom-right.
    run_phase(1'b1, '{4{24'h000000}}, 120, 1'b0);
    run_phase(1'b1, '{4{24'hFFFFFF}}, 120, 1'b0);
    repeat (3) begin
      for (int p = 0; p < NumPixels; p++) begin
        offs[p] = 24'($urandom);
      end
      run_phase(1'b1, offs, 120, 1'b0);
    end
    // Programmed offsets must be ignored with multisampling off.
    for (int p = 0; p < NumPixels; p++) begin
      offs[p] = 24'($urandom);
    end
    run_phase(1'b0, offs, 100, 1'b0);

    // Bounded final drain; anything still owed afterwards is a failure.
    spin = 0;
    while (coverage_due.size() > 0 && spin < 1000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (coverage_due.size() > 0) begin
      note_failure($sformatf("%0d coverage words never arrived", coverage_due.size()));
    end

    $display("Checked %0d quads under %0d register settings with %0d register reads.",
             n_checked, n_settings, n_reads);
    $display("Pixels seen: %0d fully covered, %0d partly covered, %0d uncovered; %0d errors.",
             n_full, n_partial, n_empty, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #(ClkPeriod * 400_000);
    $display("Timed out with %0d coverage words still owed.", coverage_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
